// ===== design/m3inv_pkg.sv =====
// Shared widths, product index tables and helpers for the 3x3 matrix inverse.
`timescale 1ns / 1ps
package m3inv_pkg;

  localparam int unsigned IN_W     = 16;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned NUM_EL   = 9;
  localparam int unsigned NUM_PROD = 18;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned COF_W    = 33;
  localparam int unsigned TERM_W   = 49;
  localparam int unsigned DET_W    = 51;
  localparam int unsigned DMAG_W   = DET_W - 1;
  localparam int unsigned QBITS    = 33;
  localparam int unsigned COF_LAT  = 4;
  // Input register, one stage per quotient bit, and the rounding register.
  localparam int unsigned DIV_LAT  = QBITS + 2;

  localparam int DEF_IN_FRAC_BITS  = 12;
  localparam int DEF_OUT_FRAC_BITS = 16;

  // Cofactor j is product 2j minus product 2j+1; each product is m[PA] * m[PB].
  localparam int PA [NUM_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int PB [NUM_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // The value 1.0 at the output scaling, saturated when it does not fit.
  function automatic logic [OUT_W-1:0] one_val(input int out_frac);
    logic [OUT_W-1:0] v;
    if (out_frac >= int'(OUT_W) - 1) begin
      v = SAT_MAX;
    end else begin
      v = OUT_W'(64'(1) << out_frac);
    end
    return v;
  endfunction

endpackage

// ===== design/matrix3x3_inverse.sv =====
// Top level of the 3x3 matrix inverse by the adjugate method.
`timescale 1ns / 1ps
// A new item is taken in every cycle in which start is high; busy never rises.
// Each item's result appears on the inv_*_o and singular_o ports for one cycle,
// marked by done_o. The item passes 40 register stages, the first clocked at
// the clock edge that took the item: four of products, cofactors and
// determinant, one of sign handling, and 35 in the nine parallel restoring
// dividers (an input register, one stage per quotient bit, and a last one that
// rounds and saturates). Results leave in the order items came in and must be
// captured in the cycle done_o is high. A zero determinant gives the identity
// matrix with singular_o set.
module matrix3x3_inverse #(
  parameter int IN_FRAC_BITS  = m3inv_pkg::DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = m3inv_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [15:0] m_r0_c0_i,
  input  logic [15:0] m_r0_c1_i,
  input  logic [15:0] m_r0_c2_i,
  input  logic [15:0] m_r1_c0_i,
  input  logic [15:0] m_r1_c1_i,
  input  logic [15:0] m_r1_c2_i,
  input  logic [15:0] m_r2_c0_i,
  input  logic [15:0] m_r2_c1_i,
  input  logic [15:0] m_r2_c2_i,
  output logic [31:0] inv_r0_c0_o,
  output logic [31:0] inv_r0_c1_o,
  output logic [31:0] inv_r0_c2_o,
  output logic [31:0] inv_r1_c0_o,
  output logic [31:0] inv_r1_c1_o,
  output logic [31:0] inv_r1_c2_o,
  output logic [31:0] inv_r2_c0_o,
  output logic [31:0] inv_r2_c1_o,
  output logic [31:0] inv_r2_c2_o,
  output logic        singular_o
);

  localparam int unsigned NE = m3inv_pkg::NUM_EL;
  localparam int unsigned CW = m3inv_pkg::COF_W;
  localparam int unsigned DW = m3inv_pkg::DMAG_W;
  localparam int unsigned OW = m3inv_pkg::OUT_W;
  localparam int unsigned DL = m3inv_pkg::DIV_LAT;
  localparam int          SH = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam logic [OW-1:0] ONE = m3inv_pkg::one_val(OUT_FRAC_BITS);

  logic [NE-1:0][m3inv_pkg::IN_W-1:0] m;
  logic                               cof_vld;
  logic [NE-1:0][CW-1:0]              cof;
  logic [m3inv_pkg::DET_W-1:0]        det;

  assign m = {m_r2_c2_i, m_r2_c1_i, m_r2_c0_i, m_r1_c2_i, m_r1_c1_i, m_r1_c0_i,
              m_r0_c2_i, m_r0_c1_i, m_r0_c0_i};

  m3inv_cof u_cof (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (start),
    .m_i   (m),
    .vld_o (cof_vld),
    .cof_o (cof),
    .det_o (det)
  );

  // Sign handling stage: magnitudes and quotient signs for the dividers.
  logic              prep_vld_q;
  logic [CW-1:0]     nmag_q [NE];
  logic [NE-1:0]     neg_q;
  logic [DW-1:0]     dmag_q;
  logic              sing_q;
  logic              det_neg;

  assign det_neg = det[m3inv_pkg::DET_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else begin
      prep_vld_q <= cof_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < int'(NE); j++) begin
      nmag_q[j] <= cof[j][CW-1] ? (CW'(0) - cof[j]) : cof[j];
      neg_q[j]  <= cof[j][CW-1] ^ det_neg;
    end
    dmag_q <= det_neg ? DW'(m3inv_pkg::DET_W'(0) - det) : DW'(det);
    sing_q <= (det == '0);
  end

  logic [NE-1:0]         div_vld;
  logic [NE-1:0][OW-1:0] div_q;

  for (genvar j = 0; j < int'(NE); j++) begin : g_div
    m3inv_div #(
      .SH(SH)
    ) u_div (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .vld_i (prep_vld_q),
      .neg_i (neg_q[j]),
      .n_i   (nmag_q[j]),
      .d_i   (dmag_q),
      .vld_o (div_vld[j]),
      .q_o   (div_q[j])
    );
  end

  // The singular flag travels alongside the divider lanes.
  logic [DL-1:0] sing_dly_q;

  always_ff @(posedge clk_i) begin
    sing_dly_q <= {sing_dly_q[DL-2:0], sing_q};
  end

  logic [NE-1:0][OW-1:0] res;
  logic                  sing_out;

  assign sing_out = sing_dly_q[DL-1];

  always_comb begin
    for (int j = 0; j < int'(NE); j++) begin
      if (sing_out) begin
        res[j] = (j % 4 == 0) ? ONE : '0;
      end else begin
        res[j] = div_q[j];
      end
    end
  end

  assign busy        = 1'b0;
  assign done_o      = div_vld[0];
  assign inv_r0_c0_o = res[0];
  assign inv_r0_c1_o = res[1];
  assign inv_r0_c2_o = res[2];
  assign inv_r1_c0_o = res[3];
  assign inv_r1_c1_o = res[4];
  assign inv_r1_c2_o = res[5];
  assign inv_r2_c0_o = res[6];
  assign inv_r2_c1_o = res[7];
  assign inv_r2_c2_o = res[8];
  assign singular_o  = sing_out;

endmodule

// ===== design/m3inv_cof.sv =====
// Cofactor and determinant pipeline: products, cofactors, row terms, determinant.
`timescale 1ns / 1ps
module m3inv_cof (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         vld_i,
  input  logic [m3inv_pkg::NUM_EL-1:0][m3inv_pkg::IN_W-1:0] m_i,
  output logic                                         vld_o,
  output logic [m3inv_pkg::NUM_EL-1:0][m3inv_pkg::COF_W-1:0] cof_o,
  output logic [m3inv_pkg::DET_W-1:0]                  det_o
);

  localparam int unsigned NP = m3inv_pkg::NUM_PROD;
  localparam int unsigned NE = m3inv_pkg::NUM_EL;

  logic [m3inv_pkg::COF_LAT-1:0] vld_q;

  logic signed [m3inv_pkg::PROD_W-1:0] prod_d [NP];
  logic signed [m3inv_pkg::PROD_W-1:0] prod_q [NP];
  logic signed [m3inv_pkg::IN_W-1:0]   abc1_q [3];
  logic signed [m3inv_pkg::IN_W-1:0]   abc2_q [3];
  logic signed [m3inv_pkg::COF_W-1:0]  cof_d  [NE];
  logic signed [m3inv_pkg::COF_W-1:0]  cof2_q [NE];
  logic signed [m3inv_pkg::COF_W-1:0]  cof3_q [NE];
  logic signed [m3inv_pkg::COF_W-1:0]  cof4_q [NE];
  logic signed [m3inv_pkg::TERM_W-1:0] term_d [3];
  logic signed [m3inv_pkg::TERM_W-1:0] term_q [3];
  logic signed [m3inv_pkg::DET_W-1:0]  det_d;
  logic signed [m3inv_pkg::DET_W-1:0]  det_q;

  always_comb begin
    logic signed [m3inv_pkg::IN_W-1:0] xa;
    logic signed [m3inv_pkg::IN_W-1:0] xb;
    for (int i = 0; i < int'(NP); i++) begin
      xa = signed'(m_i[m3inv_pkg::PA[i]]);
      xb = signed'(m_i[m3inv_pkg::PB[i]]);
      prod_d[i] = xa * xb;
    end
    for (int j = 0; j < int'(NE); j++) begin
      cof_d[j] = m3inv_pkg::COF_W'(prod_q[2*j]) - m3inv_pkg::COF_W'(prod_q[2*j+1]);
    end
    for (int r = 0; r < 3; r++) begin
      term_d[r] = m3inv_pkg::TERM_W'(abc2_q[r]) * m3inv_pkg::TERM_W'(cof2_q[3*r]);
    end
    det_d = m3inv_pkg::DET_W'(term_q[0]) + m3inv_pkg::DET_W'(term_q[1])
          + m3inv_pkg::DET_W'(term_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[m3inv_pkg::COF_LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    for (int r = 0; r < 3; r++) begin
      abc1_q[r] <= signed'(m_i[r]);
    end
    abc2_q <= abc1_q;
    cof2_q <= cof_d;
    cof3_q <= cof2_q;
    term_q <= term_d;
    cof4_q <= cof3_q;
    det_q  <= det_d;
  end

  always_comb begin
    for (int j = 0; j < int'(NE); j++) begin
      cof_o[j] = cof4_q[j];
    end
  end

  assign det_o = det_q;
  assign vld_o = vld_q[m3inv_pkg::COF_LAT-1];

endmodule

// ===== design/m3inv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, then rounding and saturation.
`timescale 1ns / 1ps
module m3inv_div #(
  parameter int SH = m3inv_pkg::DEF_IN_FRAC_BITS + m3inv_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic                               neg_i,
  input  logic [m3inv_pkg::COF_W-1:0]        n_i,
  input  logic [m3inv_pkg::DMAG_W-1:0]       d_i,
  output logic                               vld_o,
  output logic [m3inv_pkg::OUT_W-1:0]        q_o
);

  localparam int unsigned QB = m3inv_pkg::QBITS;
  localparam int unsigned DW = m3inv_pkg::DMAG_W;
  localparam int unsigned NX = QB + DW;
  localparam int unsigned OW = m3inv_pkg::OUT_W;

  logic [NX-1:0] nx;
  logic [DW-1:0] hi;
  logic          ovf_in;

  logic          vld_q [QB+1];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];
  logic [DW-1:0] r_q   [QB+1];
  logic [DW-1:0] d_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic [QB-1:0] lo_q  [QB+1];

  logic          out_vld_q;
  logic [OW-1:0] out_q;

  assign nx     = NX'(n_i) << SH;
  assign hi     = nx[NX-1:QB];
  // A quotient of 2^QB or more saturates regardless of the remaining bits.
  assign ovf_in = (hi >= d_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= neg_i;
    ovf_q[0] <= ovf_in;
    r_q[0]   <= ovf_in ? '0 : hi;
    d_q[0]   <= d_i;
    q_q[0]   <= '0;
    lo_q[0]  <= nx[QB-1:0];
  end

  for (genvar s = 1; s <= int'(QB); s++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {r_q[s-1], lo_q[s-1][QB-1]};
    assign diff = t - {1'b0, d_q[s-1]};
    assign ge   = (t >= {1'b0, d_q[s-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      neg_q[s] <= neg_q[s-1];
      ovf_q[s] <= ovf_q[s-1];
      d_q[s]   <= d_q[s-1];
      r_q[s]   <= ge ? diff[DW-1:0] : t[DW-1:0];
      q_q[s]   <= {q_q[s-1][QB-2:0], ge};
      lo_q[s]  <= lo_q[s-1] << 1;
    end
  end

  logic          rnd;
  logic [QB:0]   mag;
  logic [QB:0]   lim;
  logic [OW-1:0] res_d;

  always_comb begin
    // Round half away from zero on the magnitude.
    rnd = ({r_q[QB], 1'b0} >= {1'b0, d_q[QB]});
    mag = {1'b0, q_q[QB]} + (QB+1)'(rnd);
    lim = neg_q[QB] ? (QB+1)'(m3inv_pkg::SAT_MIN) : (QB+1)'(m3inv_pkg::SAT_MAX);
    if (ovf_q[QB] || (mag > lim)) begin
      res_d = neg_q[QB] ? m3inv_pkg::SAT_MIN : m3inv_pkg::SAT_MAX;
    end else if (neg_q[QB]) begin
      res_d = OW'((QB+1)'(0) - mag);
    end else begin
      res_d = OW'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= res_d;
  end

  assign vld_o = out_vld_q;
  assign q_o   = out_q;

endmodule

// ===== sim/matrix3x3_inverse_test.sv =====
// Testbench for the 3x3 fixed-point matrix inverse: directed and random matrices with a scoreboard.
`timescale 1ns / 1ps
module matrix3x3_inverse_test;
  import m3inv_pkg::*;

  localparam int IN_FRAC   = DEF_IN_FRAC_BITS;
  localparam int OUT_FRAC  = DEF_OUT_FRAC_BITS;
  localparam int LAT       = COF_LAT + 1 + DIV_LAT;
  localparam int MAX_CYCLES = 200000;

  typedef logic [IN_W-1:0] elem_t;
  typedef struct {
    logic [OUT_W-1:0] el [NUM_EL];
    logic             singular;
  } inverse_t;

  class inverse_scoreboard;
    inverse_t pending[$];
    int       errors;
    int       checked;
    int       singular_seen;
    int       saturated_seen;

    // Rounded, saturated quotient num * 2^sh / den, ties away from zero.
    function logic [OUT_W-1:0] scaled_quotient(longint num, longint den, int sh);
      longint unsigned n, d, q, r;
      longint res;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      if (n == 0) return '0;
      q = (n << sh) / d;
      r = (n << sh) % d;
      if (2 * r >= d) q++;
      res = neg ? -longint'(q) : longint'(q);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res[OUT_W-1:0];
    endfunction

    function void note_matrix(elem_t m [NUM_EL]);
      longint x [NUM_EL];
      longint cof [NUM_EL];
      longint det;
      inverse_t exp_inv;
      foreach (x[i]) x[i] = longint'($signed(m[i]));
      cof[0] = x[4] * x[8] - x[5] * x[7];
      cof[1] = x[2] * x[7] - x[1] * x[8];
      cof[2] = x[1] * x[5] - x[2] * x[4];
      cof[3] = x[5] * x[6] - x[3] * x[8];
      cof[4] = x[0] * x[8] - x[2] * x[6];
      cof[5] = x[2] * x[3] - x[0] * x[5];
      cof[6] = x[3] * x[7] - x[4] * x[6];
      cof[7] = x[1] * x[6] - x[0] * x[7];
      cof[8] = x[0] * x[4] - x[1] * x[3];
      det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
      if (det == 0) begin
        foreach (exp_inv.el[j]) begin
          exp_inv.el[j] = (j % 4 == 0) ?
            ((OUT_FRAC >= 31) ? SAT_MAX : OUT_W'(64'd1 << OUT_FRAC)) : '0;
        end
        exp_inv.singular = 1'b1;
        singular_seen++;
      end else begin
        foreach (exp_inv.el[j]) begin
          exp_inv.el[j] = scaled_quotient(cof[j], det, IN_FRAC + OUT_FRAC);
          if (exp_inv.el[j] == SAT_MAX || exp_inv.el[j] == SAT_MIN) saturated_seen++;
        end
        exp_inv.singular = 1'b0;
      end
      pending.push_back(exp_inv);
    endfunction

    function void check_result(inverse_t got);
      inverse_t want;
      checked++;
      if (pending.size() == 0) begin
        $error("result arrived with no matrix outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      foreach (want.el[j]) begin
        if (got.el[j] !== want.el[j]) begin
          $error("inv_r%0d_c%0d: expected %h, got %h", j / 3, j % 3, want.el[j], got.el[j]);
          errors++;
        end
      end
      if (got.singular !== want.singular) begin
        $error("singular: expected %b, got %b", want.singular, got.singular);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done;
  elem_t m_in [NUM_EL];
  logic [OUT_W-1:0] inv_out [NUM_EL];
  logic singular_o;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  inverse_scoreboard sb = new();

  initial foreach (m_in[i]) m_in[i] = '0;

  always #4 clk_i = ~clk_i;

  matrix3x3_inverse u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done_o(done),
    .m_r0_c0_i(m_in[0]), .m_r0_c1_i(m_in[1]), .m_r0_c2_i(m_in[2]),
    .m_r1_c0_i(m_in[3]), .m_r1_c1_i(m_in[4]), .m_r1_c2_i(m_in[5]),
    .m_r2_c0_i(m_in[6]), .m_r2_c1_i(m_in[7]), .m_r2_c2_i(m_in[8]),
    .inv_r0_c0_o(inv_out[0]), .inv_r0_c1_o(inv_out[1]), .inv_r0_c2_o(inv_out[2]),
    .inv_r1_c0_o(inv_out[3]), .inv_r1_c1_o(inv_out[4]), .inv_r1_c2_o(inv_out[5]),
    .inv_r2_c0_o(inv_out[6]), .inv_r2_c1_o(inv_out[7]), .inv_r2_c2_o(inv_out[8]),
    .singular_o(singular_o)
  );

  always @(posedge clk_i) begin
    inverse_t got;
    if (rst_ni) begin
      if (start && !busy) sb.note_matrix(m_in);
      if (done) begin
        foreach (got.el[j]) got.el[j] = inv_out[j];
        got.singular = singular_o;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_matrix(input elem_t m [NUM_EL]);
    @(negedge clk_i);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    m_in = m;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic send_diag(input int v0, input int v1, input int v2, input int offv);
    elem_t m [NUM_EL];
    foreach (m[i]) m[i] = IN_W'(offv);
    m[0] = IN_W'(v0);
    m[4] = IN_W'(v1);
    m[8] = IN_W'(v2);
    send_matrix(m);
  endtask

  function automatic elem_t signed_range(int lim);
    return IN_W'($urandom_range(2 * lim) - lim);
  endfunction

  // Well-conditioned matrices, with fully random, tiny, mixed-range and singular ones mixed in.
  task automatic send_random_matrix();
    elem_t m [NUM_EL];
    int kind;
    kind = $urandom_range(99);
    if (kind < 40) begin
      foreach (m[i]) m[i] = signed_range(1024);
      for (int i = 0; i < 9; i += 4) begin
        m[i] = IN_W'($urandom_range(16384, 2048));
        if ($urandom_range(1)) m[i] = -m[i];
      end
    end else if (kind < 60) begin
      foreach (m[i]) m[i] = IN_W'($urandom);
    end else if (kind < 75) begin
      foreach (m[i]) m[i] = signed_range(64);
    end else if (kind < 90) begin
      foreach (m[i]) m[i] = ($urandom_range(3) == 0) ? IN_W'($urandom) : signed_range(8192);
    end else begin
      foreach (m[i]) m[i] = IN_W'($urandom);
      case ($urandom_range(2))
        0: for (int c = 0; c < 3; c++) m[6 + c] = m[c];
        1: for (int r = 0; r < 3; r++) m[3 * r + 2] = m[3 * r];
        default: for (int c = 0; c < 3; c++) m[3 + c] = '0;
      endcase
    end
    send_matrix(m);
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    elem_t m [NUM_EL];
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: identity, zero, extremes, saturation, singular forms, zero cofactors.
    send_diag(4096, 4096, 4096, 0);
    send_diag(0, 0, 0, 0);
    send_diag(32767, 32767, 32767, 0);
    send_diag(-32768, -32768, -32768, 0);
    send_diag(1, 1, 1, 0);
    send_diag(-1, 1, -1, 0);
    send_diag(32767, -32768, 1, 0);
    send_diag(-32768, -32768, -32768, -32768);
    send_diag(32767, 32767, 32767, 32767);
    send_diag(-32768, 32767, -32768, 32767);
    send_diag(8192, 2048, -4096, 0);
    send_diag(3, 3, 3, 0);
    send_diag(4096, 4096, 4096, 4096);
    foreach (m[i]) m[i] = IN_W'((i % 2) ? -32768 : 32767);
    send_matrix(m);
    foreach (m[i]) m[i] = IN_W'(i + 1);
    send_matrix(m);
    foreach (m[i]) m[i] = IN_W'((i == 2 || i == 4 || i == 6) ? 4096 : 0);
    send_matrix(m);
    foreach (m[i]) m[i] = IN_W'(4096 * (i % 3 + 1) - 16384 * (i / 3));
    send_matrix(m);
    foreach (m[i]) m[i] = IN_W'((i == 1 || i == 5 || i == 6) ? -3 : 0);
    send_matrix(m);
    drain();

    sender_idle_pct = 26;
    repeat (210) send_random_matrix();
    drain();
    sender_idle_pct = 68;
    repeat (210) send_random_matrix();
    drain();
    sender_idle_pct = 0;
    repeat (214) send_random_matrix();
    drain();

    repeat (LAT + 10) @(posedge clk_i);
    $display("Checked %0d inverses: %0d singular, %0d saturated elements.",
             sb.checked, sb.singular_seen, sb.saturated_seen);
    $display("Sender gaps of 26%%, 68%% and none, with full drains between phases.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/m3inv_pkg.sv
design/m3inv_cof.sv
design/m3inv_div.sv
design/matrix3x3_inverse.sv
sim/matrix3x3_inverse_test.sv
